>>> src/pltd_pkg.sv
package pltd_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] PageMark      = 16'hFFFF;
  localparam logic [WordW-1:0] PageCountRst  = 16'd1;
  localparam logic [WordW-1:0] MaxLineLenRst = 16'd80;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPageCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLineLen = 2'd1;

  typedef enum logic [1:0] {
    EvText  = 2'd0,
    EvEmpty = 2'd1,
    EvEnd   = 2'd2,
    EvError = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e      event_kind;
    logic [ByteW-1:0] text_byte;
    logic [WordW-1:0] page_number;
    logic [WordW-1:0] line_number;
    logic [WordW-1:0] line_length;
    logic             last_in_line;
  } result_t;

  function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
    return (v == PageMark) ? v : v + 16'd1;
  endfunction

endpackage

>>> src/pltd_if.sv
interface pltd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source(output valid, output data_byte, output block_start, input ready);
  modport sink(input valid, input data_byte, input block_start, output ready);
endinterface

interface pltd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  text_byte;
  logic [15:0] page_number;
  logic [15:0] line_number;
  logic [15:0] line_length;
  logic        last_in_line;

  modport source(output valid, output event_kind, output text_byte, output page_number,
                 output line_number, output line_length, output last_in_line, input ready);
  modport sink(input valid, input event_kind, input text_byte, input page_number,
               input line_number, input line_length, input last_in_line, output ready);
endinterface

>>> src/pltd_core.sv
module pltd_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   block_start_i,
  input  logic [15:0]            page_count_i,
  input  logic [15:0]            max_line_len_i,
  output logic                   res_valid_o,
  output pltd_pkg::result_t      res_o
);
  import pltd_pkg::*;

  typedef enum logic [2:0] {
    PhLenHigh = 3'd0,
    PhLenLow  = 3'd1,
    PhText    = 3'd2,
    PhDone    = 3'd3,
    PhError   = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d, phase_eff;
  logic [ByteW-1:0] high_byte_q, high_byte_d;
  logic [WordW-1:0] bytes_rem_q, bytes_rem_d;
  logic [WordW-1:0] cur_len_q, cur_len_d;
  logic [WordW-1:0] page_q, page_d, page_eff;
  logic [WordW-1:0] line_q, line_d, line_eff;
  logic [WordW-1:0] pages_rem_q, pages_rem_d, pages_rem_eff;
  logic             after_mark_q, after_mark_d, after_mark_eff;
  logic [WordW-1:0] len_word;
  logic             last_byte;

  // block_start restarts the phase and the page, line and remaining-page counts before this word is decoded
  assign phase_eff      = block_start_i ? PhLenHigh : phase_q;
  assign page_eff       = block_start_i ? PageCountRst : page_q;
  assign line_eff       = block_start_i ? 16'd1 : line_q;
  assign pages_rem_eff  = block_start_i ? page_count_i : pages_rem_q;
  assign after_mark_eff = block_start_i ? 1'b0 : after_mark_q;

  assign len_word  = {high_byte_q, data_byte_i};
  assign last_byte = (bytes_rem_q <= 16'd1);

  always_comb begin
    phase_d      = phase_eff;
    high_byte_d  = high_byte_q;
    bytes_rem_d  = bytes_rem_q;
    cur_len_d    = cur_len_q;
    page_d       = page_eff;
    line_d       = line_eff;
    pages_rem_d  = pages_rem_eff;
    after_mark_d = after_mark_eff;

    res_valid_o        = 1'b0;
    res_o.event_kind   = EvText;
    res_o.text_byte    = '0;
    res_o.page_number  = page_eff;
    res_o.line_number  = line_eff;
    res_o.line_length  = '0;
    res_o.last_in_line = 1'b0;

    case (phase_eff)
      PhLenHigh: begin
        high_byte_d = data_byte_i;
        phase_d     = PhLenLow;
      end
      PhLenLow: begin
        if (pages_rem_eff == '0) begin
          phase_d          = PhDone;
          res_valid_o      = 1'b1;
          res_o.event_kind = EvEnd;
        end else if (len_word == PageMark && !after_mark_eff) begin
          if (pages_rem_eff <= 16'd1) begin
            pages_rem_d      = '0;
            phase_d          = PhDone;
            res_valid_o      = 1'b1;
            res_o.event_kind = EvEnd;
          end else begin
            pages_rem_d  = pages_rem_eff - 16'd1;
            page_d       = sat_inc(page_eff);
            line_d       = 16'd1;
            after_mark_d = 1'b1;
            phase_d      = PhLenHigh;
          end
        end else begin
          after_mark_d = 1'b0;
          if (len_word > max_line_len_i) begin
            phase_d           = PhError;
            res_valid_o       = 1'b1;
            res_o.event_kind  = EvError;
            res_o.line_length = len_word;
          end else if (len_word == '0) begin
            cur_len_d        = '0;
            res_valid_o      = 1'b1;
            res_o.event_kind = EvEmpty;
            line_d           = sat_inc(line_eff);
            phase_d          = PhLenHigh;
          end else begin
            cur_len_d   = len_word;
            bytes_rem_d = len_word;
            phase_d     = PhText;
          end
        end
      end
      PhText: begin
        res_valid_o        = 1'b1;
        res_o.event_kind   = EvText;
        res_o.text_byte    = data_byte_i;
        res_o.line_length  = cur_len_q;
        res_o.last_in_line = last_byte;
        if (last_byte) begin
          bytes_rem_d = '0;
          line_d      = sat_inc(line_eff);
          phase_d     = PhLenHigh;
        end else begin
          bytes_rem_d = bytes_rem_q - 16'd1;
        end
      end
      default: ;  // done or error: words dropped until block_start
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLenHigh;
      high_byte_q  <= '0;
      bytes_rem_q  <= '0;
      cur_len_q    <= '0;
      page_q       <= PageCountRst;
      line_q       <= 16'd1;
      pages_rem_q  <= PageCountRst;
      after_mark_q <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      high_byte_q  <= high_byte_d;
      bytes_rem_q  <= bytes_rem_d;
      cur_len_q    <= cur_len_d;
      page_q       <= page_d;
      line_q       <= line_d;
      pages_rem_q  <= pages_rem_d;
      after_mark_q <= after_mark_d;
    end
  end

endmodule

>>> src/pltd_out_reg.sv
module pltd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pltd_pkg::result_t res_i,
  output logic              free_o,
  pltd_out_if.source        out_o
);
  import pltd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // can take a new word when empty or when the current one leaves this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.event_kind   = data_q.event_kind;
  assign out_o.text_byte    = data_q.text_byte;
  assign out_o.page_number  = data_q.page_number;
  assign out_o.line_number  = data_q.line_number;
  assign out_o.line_length  = data_q.line_length;
  assign out_o.last_in_line = data_q.last_in_line;

endmodule

>>> src/paged_text_line_deframer_top.sv
// A result word appears at the output register in the cycle after its input word is accepted.
// Throughput: one input word per cycle; input stalls only while a result waits unread.
// Each word is decoded by the combinational phase and counter update logic.
// Reset (rst_ni, async, active low) clears the phase, counters and output valid,
// and restores page_count = 1 and max_line_length = 80.
module paged_text_line_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pltd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pltd_pkg::WordW-1:0]    cfg_data_i,
  pltd_in_if.sink                       in_i,
  pltd_out_if.source                    out_o
);
  import pltd_pkg::*;

  logic [WordW-1:0] page_count_q;
  logic [WordW-1:0] max_line_len_q;
  logic             accept;
  logic             res_valid;
  logic             out_free;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q   <= PageCountRst;
      max_line_len_q <= MaxLineLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPageCount:  page_count_q   <= cfg_data_i;
        CfgMaxLineLen: max_line_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = out_free;
  assign accept     = in_i.valid && out_free;

  pltd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_i.data_byte),
    .block_start_i  (in_i.block_start),
    .page_count_i   (page_count_q),
    .max_line_len_i (max_line_len_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  pltd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid |=> out_o.valid)
    else $error("accepted result word did not reach the output");

  a_text_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.event_kind == EvText |-> out_o.line_length != '0)
    else $error("text word with zero line length");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.event_kind == EvEmpty |->
      out_o.line_length == '0 && out_o.text_byte == '0 && !out_o.last_in_line)
    else $error("empty line word carries payload");

  a_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.page_number != '0 && out_o.line_number != '0)
    else $error("page or line number is zero");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pltd_pkg::*;

  localparam int unsigned StuckLimit = 1000;
  // the block has only two registers, this index must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum logic [2:0] {
    StLenHigh,
    StLenLow,
    StText,
    StDone,
    StError
  } parse_state_e;

  class deframe_checker;
    logic [WordW-1:0] cfg_pages;
    logic [WordW-1:0] cfg_max_len;

    parse_state_e     state;
    logic [ByteW-1:0] len_high;
    logic [WordW-1:0] text_left;
    logic [WordW-1:0] line_len;
    logic [WordW-1:0] page_no;
    logic [WordW-1:0] line_no;
    logic [WordW-1:0] pages_rem;
    logic             after_mark;

    result_t          expected_events[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      reset_all();
    endfunction

    function void reset_all();
      cfg_pages   = PageCountRst;
      cfg_max_len = MaxLineLenRst;
      restart();
    endfunction

    function void restart();
      state      = StLenHigh;
      len_high   = '0;
      text_left  = '0;
      line_len   = '0;
      page_no    = 16'd1;
      line_no    = 16'd1;
      pages_rem  = cfg_pages;
      after_mark = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
      if (idx == CfgPageCount) cfg_pages = val;
      else if (idx == CfgMaxLineLen) cfg_max_len = val;
    endfunction

    function logic [WordW-1:0] count_up(logic [WordW-1:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void push(event_kind_e kind, logic [ByteW-1:0] b, logic [WordW-1:0] len,
                       logic last);
      result_t r;
      r.event_kind   = kind;
      r.text_byte    = b;
      r.page_number  = page_no;
      r.line_number  = line_no;
      r.line_length  = len;
      r.last_in_line = last;
      expected_events.push_back(r);
    endfunction

    function void note_word(logic [ByteW-1:0] b, logic start);
      logic [WordW-1:0] w;
      if (start) restart();
      case (state)
        StLenHigh: begin
          len_high = b;
          state    = StLenLow;
        end
        StLenLow: begin
          w = {len_high, b};
          if (pages_rem == 0) begin
            state = StDone;
            push(EvEnd, '0, '0, 1'b0);
          end else if (w == PageMark && !after_mark) begin
            if (pages_rem <= 1) begin
              // marker on the last page closes the block, page and line counters stay put
              pages_rem = '0;
              state     = StDone;
              push(EvEnd, '0, '0, 1'b0);
            end else begin
              pages_rem  = pages_rem - 16'd1;
              page_no    = count_up(page_no);
              line_no    = 16'd1;
              after_mark = 1'b1;
              state      = StLenHigh;
            end
          end else begin
            after_mark = 1'b0;
            if (w > cfg_max_len) begin
              state = StError;
              push(EvError, '0, w, 1'b0);
            end else if (w == 0) begin
              line_len = '0;
              push(EvEmpty, '0, '0, 1'b0);
              line_no = count_up(line_no);
              state   = StLenHigh;
            end else begin
              line_len  = w;
              text_left = w;
              state     = StText;
            end
          end
        end
        StText: begin
          push(EvText, b, line_len, text_left <= 1);
          if (text_left <= 1) begin
            text_left = '0;
            line_no   = count_up(line_no);
            state     = StLenHigh;
          end else begin
            text_left = text_left - 16'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function string fmt(result_t r);
      return $sformatf("kind=%0d byte=%02h page=%0d line=%0d len=%0d last=%0d",
                       r.event_kind, r.text_byte, r.page_number, r.line_number,
                       r.line_length, r.last_in_line);
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected word %s", $realtime, fmt(got));
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind || got.text_byte !== want.text_byte ||
          got.page_number !== want.page_number || got.line_number !== want.line_number ||
          got.line_length !== want.line_length || got.last_in_line !== want.last_in_line) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch\n  exp %s\n  got %s", $realtime, fmt(want), fmt(got));
      end
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [WordW-1:0]    cfg_data_i;

  pltd_in_if  in_if();
  pltd_out_if out_if();

  paged_text_line_deframer_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  deframe_checker sb = new();

  logic        bulk = 1'b0;
  logic        in_idle_on = 1'b1;
  logic        out_idle_on = 1'b1;
  int unsigned out_stall = 0;
  int unsigned stuck_cycles = 0;
  int unsigned sent_words = 0;
  result_t     seen;

  always #2 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [WordW-1:0] pick_len(input logic [WordW-1:0] max_len);
    int unsigned r;
    logic [WordW-1:0] cap;
    r   = $urandom_range(0, 19);
    cap = (max_len > 12) ? 16'd12 : max_len;
    if (r == 19 && max_len != 16'hFFFF) return max_len + 16'd1;
    if (r == 0 || max_len == 0) return 16'd0;
    if (r == 18 && max_len <= 80) return max_len;
    return 16'($urandom_range(1, cap));
  endfunction

  // result side: check accepted words, drive ready with random stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.event_kind   = event_kind_e'(out_if.event_kind);
      seen.text_byte    = out_if.text_byte;
      seen.page_number  = out_if.page_number;
      seen.line_number  = out_if.line_number;
      seen.line_length  = out_if.line_length;
      seen.last_in_line = out_if.last_in_line;
      sb.check_event(seen);
    end
    if ($urandom_range(0, 299) == 0) out_idle_on = !out_idle_on;
    if (bulk || !out_idle_on) begin
      out_stall = 0;
      out_if.ready <= 1'b1;
    end else if (out_stall != 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_stall = idle_len();
      if (out_stall != 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [ByteW-1:0] b, input logic start);
    int unsigned g;
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.block_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(b, start);
    sent_words++;
    g = (bulk || !in_idle_on) ? 0 : idle_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_len(input logic [WordW-1:0] w, input logic start);
    send_word(w[15:8], start);
    send_word(w[7:0], 1'b0);
  endtask

  task automatic send_line(input logic [WordW-1:0] len, input logic start);
    send_len(len, start);
    if (len <= sb.cfg_max_len)
      for (int unsigned i = 0; i < len; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // a block, lines may run too long; many pages cut it short, the next start restarts it
  task automatic send_block();
    int unsigned pages;
    int unsigned lines;
    logic        first;
    pages = (sb.cfg_pages <= 4) ? sb.cfg_pages : $urandom_range(1, 4);
    first = 1'b1;
    for (int unsigned p = 0; p < pages; p++) begin
      lines = $urandom_range(0, 3);
      for (int unsigned l = 0; l < lines; l++) begin
        send_line(pick_len(sb.cfg_max_len), first);
        first = 1'b0;
      end
      send_len(PageMark, first);
      first = 1'b0;
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(2, 16);
    repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // stop sending and let every expected word come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [WordW-1:0] pages, input logic [WordW-1:0] max_len);
    write_reg(CfgPageCount, pages);
    write_reg(CfgMaxLineLen, max_len);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  logic [WordW-1:0] phase_pages[6] = '{16'd2, 16'd1, 16'd4, 16'd65535, 16'd1, 16'd3};
  logic [WordW-1:0] phase_max[6]   = '{16'd12, 16'd0, 16'd65535, 16'd5, 16'd80, 16'd1};

  initial begin
    int unsigned mark;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgPageCount;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.block_start = 1'b0;
    out_if.ready      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: one page, lines up to 80 bytes
    send_len(16'd0, 1'b1);
    send_len(16'd1, 1'b0);
    send_word(8'hFF, 1'b0);
    send_len(16'd2, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h5A, 1'b0);
    send_len(16'd81, 1'b0);
    send_word(8'hC3, 1'b0);        // dropped after the length error
    send_len(PageMark, 1'b1);      // marker on the only page ends the block
    send_word(8'h00, 1'b0);        // dropped after end of block
    drain();

    set_regs(16'd3, 16'hFFFE);
    write_reg(CfgSpare, 16'h0001);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_len(PageMark, 1'b1);
    send_len(PageMark, 1'b0);      // second marker in a row is a length: too long
    send_len(PageMark, 1'b1);
    send_len(16'd0, 1'b0);
    send_len(PageMark, 1'b0);
    send_len(16'd0, 1'b0);
    send_len(PageMark, 1'b0);      // last page left, block ends here

    for (int unsigned ph = 0; ph < 6; ph++) begin
      drain();
      set_regs(phase_pages[ph], phase_max[ph]);
      mark = sent_words;
      while (sent_words - mark < 120) begin
        in_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 39) == 0) drain();
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_block();
      end
    end

    // block at full rate, words back to back, ended by the marker on its last page
    drain();
    set_regs(16'd16, 16'd0);
    bulk = 1'b1;
    send_len(16'd0, 1'b1);
    repeat (40) send_len(16'd0, 1'b0);
    repeat (15) begin
      send_len(PageMark, 1'b0);
      send_len(16'd0, 1'b0);
    end
    send_len(PageMark, 1'b0);
    bulk = 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pltd_pkg.sv
src/pltd_if.sv
src/pltd_core.sv
src/pltd_out_reg.sv
src/paged_text_line_deframer_top.sv
test/tb_top.sv
